@@ rtl/cddc_pkg.sv @@
// Shared types, opcodes and segment codes for the clock dial display and chime block.
// No dependencies; every rtl module imports this package.

package cddc_pkg;

  localparam int unsigned HOUR_W   = 4;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned LEVEL_W  = 16;
  localparam int unsigned OP_W     = 3;

  localparam logic [HOUR_W-1:0]  HOUR_MAX   = 4'd12;
  localparam logic [ANGLE_W-1:0] DIAL_STEP  = 9'd30;
  localparam logic [3:0]         DIGIT_MAX  = 4'd9;
  localparam logic [3:0]         DEGREE_IDX = 4'd10;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN   = 3'd0,
    OP_HOUR   = 3'd1,
    OP_BEEP   = 3'd2,
    OP_MUTE   = 3'd3,
    OP_LIGHT  = 3'd4,
    OP_SAMPLE = 3'd5
  } cddc_op_e;

  // One-hot event strobes for the item being processed this cycle.
  typedef struct packed {
    logic scan;
    logic hour;
    logic beep;
    logic mute;
    logic light;
    logic sample;
  } cddc_evt_t;

  // 7-segment codes: digits 0..9, then the degree sign.
  function automatic logic [11:0] seg_lookup(input logic [3:0] idx);
    logic [11:0] code;
    case (idx)
      4'd0:    code = 12'hFC0;
      4'd1:    code = 12'h600;
      4'd2:    code = 12'hDA0;
      4'd3:    code = 12'hF20;
      4'd4:    code = 12'h660;
      4'd5:    code = 12'hB60;
      4'd6:    code = 12'hBE0;
      4'd7:    code = 12'hE00;
      4'd8:    code = 12'hFE0;
      4'd9:    code = 12'hF60;
      4'd10:   code = 12'hC60;
      default: code = 12'h000;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/cddc_display.sv @@
// Hour counter, dial angle, digit scan and 24-bit display frame store.
// Depends on cddc_pkg.

module cddc_display import cddc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cddc_evt_t         evt_i,
  output logic [HOUR_W-1:0] hour_o,
  output logic [7:0]        frame0_o,
  output logic [7:0]        frame1_o,
  output logic [7:0]        frame2_o
);

  localparam logic [1:0] POS_HUNDREDS = 2'd0;
  localparam logic [1:0] POS_TENS     = 2'd1;
  localparam logic [1:0] POS_DEGREE   = 2'd3;

  logic [HOUR_W-1:0]  hour_q, hour_d;
  logic [ANGLE_W-1:0] dial_q, dial_d;
  logic [ANGLE_W-1:0] scan_q, scan_d;
  logic [1:0]         pos_q, pos_d;
  logic               blank_q, blank_d;
  logic [7:0]         f0_q, f0_d, f1_q, f1_d, f2_q, f2_d;

  logic [14:0]        prod_hund;
  logic [16:0]        prod_tens;
  logic [ANGLE_W-1:0] quo;
  logic [6:0]         place;
  logic [3:0]         digit;
  logic [10:0]        place_sub;
  logic [ANGLE_W-1:0] scan_rem;
  logic [3:0]         seg_idx;
  logic               seg_en;
  logic [11:0]        seg;
  logic [HOUR_W-1:0]  hour_inc;

  // Divide by the place value with reciprocal multiplies; exact for 9-bit angles.
  always_comb begin
    prod_hund = 15'(scan_q) * 15'd41;
    prod_tens = 17'(scan_q) * 17'd205;
    case (pos_q)
      POS_HUNDREDS: begin
        quo   = ANGLE_W'(prod_hund >> 12);
        place = 7'd100;
      end
      POS_TENS: begin
        quo   = ANGLE_W'(prod_tens >> 11);
        place = 7'd10;
      end
      default: begin
        quo   = scan_q;
        place = 7'd1;
      end
    endcase
    digit     = (quo > ANGLE_W'(DIGIT_MAX)) ? DIGIT_MAX : quo[3:0];
    place_sub = 11'(digit) * 11'(place);
    scan_rem  = scan_q - place_sub[ANGLE_W-1:0];
  end

  always_comb begin
    hour_d   = hour_q;
    dial_d   = dial_q;
    scan_d   = scan_q;
    pos_d    = pos_q;
    blank_d  = blank_q;
    f0_d     = f0_q;
    f1_d     = f1_q;
    f2_d     = f2_q;
    seg_en   = 1'b0;
    seg_idx  = digit;
    hour_inc = hour_q + 4'd1;

    if (evt_i.scan) begin
      f0_d = 8'h00;
      f1_d = f1_q & 8'hF0;
      if (pos_q != POS_DEGREE) begin
        if (quo == '0 && pos_q == POS_HUNDREDS) begin
          blank_d = 1'b1;
        end else if (quo == '0 && blank_q) begin
          // hold the leading zero blank
          blank_d = blank_q;
        end else begin
          blank_d = 1'b0;
          scan_d  = scan_rem;
          seg_en  = 1'b1;
        end
      end else if (dial_q != '0) begin
        seg_en  = 1'b1;
        seg_idx = DEGREE_IDX;
      end
      if (seg_en) begin
        f0_d = f0_d | seg[7:0];
        f1_d = f1_d | {4'h0, seg[11:8]};
      end
      // accumulate the hour bar
      if (hour_q != '0) begin
        if (hour_q <= 4'd8) begin
          f2_d = f2_d | (8'h80 >> (hour_q - 4'd1));
        end else begin
          f1_d = f1_d | (8'h80 >> 3'(hour_q - 4'd9));
        end
      end
      f0_d = f0_d | {4'h0, 4'b1000 >> pos_q};
      if (pos_q == POS_DEGREE) begin
        scan_d  = dial_q;
        pos_d   = POS_HUNDREDS;
        blank_d = 1'b0;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end else if (evt_i.hour) begin
      hour_d = hour_inc;
      dial_d = dial_q + DIAL_STEP;
      if (hour_inc > HOUR_MAX) begin
        hour_d = '0;
        dial_d = '0;
        f0_d   = 8'h00;
        f1_d   = 8'h00;
        f2_d   = 8'h00;
      end
    end
  end

  assign seg = seg_lookup(seg_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour_q  <= '0;
      dial_q  <= '0;
      scan_q  <= '0;
      pos_q   <= POS_HUNDREDS;
      blank_q <= 1'b0;
      f0_q    <= 8'h00;
      f1_q    <= 8'h00;
      f2_q    <= 8'h00;
    end else begin
      hour_q  <= hour_d;
      dial_q  <= dial_d;
      scan_q  <= scan_d;
      pos_q   <= pos_d;
      blank_q <= blank_d;
      f0_q    <= f0_d;
      f1_q    <= f1_d;
      f2_q    <= f2_d;
    end
  end

  assign hour_o   = hour_q;
  assign frame0_o = f0_d;
  assign frame1_o = f1_d;
  assign frame2_o = f2_d;

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hour_q <= HOUR_MAX)
    else $error("hour count beyond twelve");

  a_dial_tracks_hour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dial_q == ANGLE_W'(ANGLE_W'(hour_q) * DIAL_STEP))
    else $error("dial angle out of step with hour count");

endmodule

@@ rtl/cddc_chime.sv @@
// Hourly chime sequencer: arms on a scan, plays beeps on beep ticks, mute toggle.
// Depends on cddc_pkg.

module cddc_chime import cddc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cddc_evt_t         evt_i,
  input  logic [HOUR_W-1:0] hour_i,
  output logic              tone_o,
  output logic              muted_o
);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [HOUR_W-1:0] beeps_q, beeps_d;
  logic              phase_q, phase_d;
  logic              tone_q, tone_d;
  logic              muted_q, muted_d;

  always_comb begin
    active_d = active_q;
    done_d   = done_q;
    beeps_d  = beeps_q;
    phase_d  = phase_q;
    tone_d   = tone_q;
    muted_d  = muted_q;
    if (evt_i.scan) begin
      if (!muted_q && !active_q && !done_q) begin
        active_d = 1'b1;
        beeps_d  = hour_i;
      end
    end
    if (evt_i.hour) begin
      done_d = 1'b0;
    end
    if (evt_i.beep && active_q) begin
      if (beeps_q != '0 && beeps_q <= HOUR_MAX) begin
        if (phase_q) begin
          tone_d  = 1'b1;
          phase_d = 1'b0;
        end else begin
          tone_d  = 1'b0;
          phase_d = 1'b1;
          beeps_d = beeps_q - 4'd1;
        end
      end else begin
        // count spent: end the chime until the next hour
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
    if (evt_i.mute) begin
      muted_d = !muted_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      beeps_q  <= '0;
      phase_q  <= 1'b0;
      tone_q   <= 1'b0;
      muted_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      beeps_q  <= beeps_d;
      phase_q  <= phase_d;
      tone_q   <= tone_d;
      muted_q  <= muted_d;
    end
  end

  assign tone_o  = tone_d;
  assign muted_o = muted_d;

  a_active_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(active_q && done_q))
    else $error("chime both active and done");

endmodule

@@ rtl/clock_dial_display_chime.sv @@
// Clock dial display and chime controller: takes one event transaction per cycle (scan,
// hour, beep, mute, light press, light sample) while m_axis_tready_i is high, and returns
// exactly one result transaction for each. An event is held in the input register, is
// decoded and applied to the display, chime and backlight state, and its result lands in
// the output register; the output register sets the sustained rate, and s_axis_tready_o
// follows m_axis_tready_i within the cycle when both stages are full. Depends on
// cddc_pkg, cddc_display and cddc_chime.

module clock_dial_display_chime import cddc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  input  logic [15:0]   s_axis_tdata_i,  // [11:0] light_sample, [15:12] zero
  input  logic [OP_W-1:0] s_axis_tuser_i, // [2:0] opcode
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [7:0] frame_byte0, [15:8] frame_byte1, [23:16] frame_byte2, [24] tone_on,
  // [25] mute_led, [26] boost_led, [42:27] backlight_level, [47:43] zero
  output logic [47:0]   m_axis_tdata_o,
  output logic          m_axis_tuser_o   // [0] frame_send
);

  logic                in_valid_q, in_valid_d;
  logic [OP_W-1:0]     op_q;
  logic [SAMPLE_W-1:0] sample_q;
  logic                proc;
  logic                s_fire;
  cddc_evt_t           evt;

  logic                out_valid_q, out_valid_d;
  logic [47:0]         out_data_q;
  logic                out_send_q;

  logic [HOUR_W-1:0]   hour;
  logic [7:0]          frame0, frame1, frame2;
  logic                tone, muted;
  logic                boost_q, boost_d;
  logic [LEVEL_W-1:0]  level_q, level_d;
  logic [47:0]         result;

  assign proc            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || proc;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    evt = '0;
    if (proc) begin
      case (op_q)
        OP_SCAN:   evt.scan   = 1'b1;
        OP_HOUR:   evt.hour   = 1'b1;
        OP_BEEP:   evt.beep   = 1'b1;
        OP_MUTE:   evt.mute   = 1'b1;
        OP_LIGHT:  evt.light  = 1'b1;
        OP_SAMPLE: evt.sample = 1'b1;
        default:   evt = '0;
      endcase
    end
  end

  cddc_display u_display (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .evt_i    (evt),
    .hour_o   (hour),
    .frame0_o (frame0),
    .frame1_o (frame1),
    .frame2_o (frame2)
  );

  cddc_chime u_chime (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .evt_i   (evt),
    .hour_i  (hour),
    .tone_o  (tone),
    .muted_o (muted)
  );

  // Backlight level: sample times four, or times twelve when boosted.
  always_comb begin
    boost_d = evt.light ? !boost_q : boost_q;
    level_d = level_q;
    if (evt.sample) begin
      level_d = {2'b00, sample_q, 2'b00}
              + (boost_q ? {1'b0, sample_q, 3'b000} : {LEVEL_W{1'b0}});
    end
  end

  always_comb begin
    result = '0;
    if (evt.scan) begin
      result[23:0] = {frame2, frame1, frame0};
    end
    result[24]    = tone;
    result[25]    = muted;
    result[26]    = boost_d;
    result[42:27] = level_d;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (proc) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      boost_q     <= 1'b0;
      level_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      boost_q     <= boost_d;
      level_q     <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      op_q     <= s_axis_tuser_i;
      sample_q <= s_axis_tdata_i[SAMPLE_W-1:0];
    end
    if (proc) begin
      out_data_q <= result;
      out_send_q <= evt.scan;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_send_q;

  a_proc_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |=> m_axis_tvalid_o)
    else $error("processed item produced no result");

  a_no_send_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[23:0] == 24'h000000)
    else $error("frame bytes present without a frame send");

endmodule

@@ verif/chime_display_checker.sv @@
// Checker for clock_dial_display_chime: watches both stream channels, predicts each result
// and compares it field by field. Depends on cddc_pkg for opcodes and field widths.
`timescale 1ns / 1ps

module chime_display_checker import cddc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid_i,
  input  logic            s_axis_tready_i,
  input  logic [15:0]     s_axis_tdata_i,   // [11:0] light_sample, [15:12] zero
  input  logic [OP_W-1:0] s_axis_tuser_i,   // [2:0] opcode
  input  logic            m_axis_tvalid_i,
  input  logic            m_axis_tready_i,
  // [7:0] frame_byte0, [15:8] frame_byte1, [23:16] frame_byte2, [24] tone_on,
  // [25] mute_led, [26] boost_led, [42:27] backlight_level, [47:43] zero
  input  logic [47:0]     m_axis_tdata_i,
  input  logic            m_axis_tuser_i,   // [0] frame_send
  output int unsigned     mismatches_o,
  output int unsigned     outstanding_o
);

  typedef struct packed {
    logic               frame_send;
    logic [7:0]         frame_byte0;
    logic [7:0]         frame_byte1;
    logic [7:0]         frame_byte2;
    logic               tone_on;
    logic               mute_led;
    logic               boost_led;
    logic [LEVEL_W-1:0] backlight_level;
  } panel_status_t;

  // Shadow copy of the display, chime and backlight state.
  logic [HOUR_W-1:0]  hour;
  logic [ANGLE_W-1:0] dial_angle;
  logic [ANGLE_W-1:0] scan_angle;
  logic [1:0]         scan_pos;
  logic               blank_zero;
  logic [7:0]         frame [3];
  logic               chime_active;
  logic               chime_done;
  logic [HOUR_W-1:0]  beeps_left;
  logic               beep_phase;
  logic               tone;
  logic               muted;
  logic               boost;
  logic [LEVEL_W-1:0] backlight;

  panel_status_t expected_status_q [$];
  panel_status_t predicted;
  panel_status_t observed;
  int unsigned   fault_count;

  assign mismatches_o = fault_count;

  function automatic logic [11:0] segment_pattern(input int unsigned glyph);
    case (glyph)
      0:       return 12'hFC0;
      1:       return 12'h600;
      2:       return 12'hDA0;
      3:       return 12'hF20;
      4:       return 12'h660;
      5:       return 12'hB60;
      6:       return 12'hBE0;
      7:       return 12'hE00;
      8:       return 12'hFE0;
      9:       return 12'hF60;
      default: return 12'hC60;
    endcase
  endfunction

  task automatic light_segments(input logic [11:0] pattern);
    frame[0] = frame[0] | pattern[7:0];
    frame[1] = frame[1] | {4'b0000, pattern[11:8]};
  endtask

  task automatic apply_event(input cddc_op_e op, input logic [SAMPLE_W-1:0] sample,
                             output panel_status_t status);
    logic [1:0]  pos;
    int unsigned place;
    int unsigned digit;
    logic        sent;
    sent = 1'b0;
    case (op)
      OP_SCAN: begin
        pos      = scan_pos;
        frame[0] = 8'h00;
        frame[1] = frame[1] & 8'hF0;
        if (pos != 2'd3) begin
          place = (pos == 2'd0) ? 100 : (pos == 2'd1) ? 10 : 1;
          digit = scan_angle / place;
          if (digit == 0 && pos == 2'd0) begin
            blank_zero = 1'b1;
          end else if (digit == 0 && blank_zero) begin
            // leading zero stays dark
          end else begin
            if (digit > DIGIT_MAX) digit = DIGIT_MAX;
            blank_zero = 1'b0;
            scan_angle = 9'(int'(scan_angle) - int'(digit * place));
            light_segments(segment_pattern(digit));
          end
        end else if (dial_angle != '0) begin
          light_segments(segment_pattern(DEGREE_IDX));
        end
        // arm the chime, then add this hour to the LED bar
        if (!muted && !chime_active && !chime_done) begin
          chime_active = 1'b1;
          beeps_left   = hour;
        end
        if (hour != '0) begin
          if (hour <= 4'd8) frame[2] = frame[2] | (8'h80 >> (hour - 4'd1));
          else              frame[1] = frame[1] | (8'h80 >> (hour - 4'd9));
        end
        frame[0] = frame[0] | (8'h08 >> pos);
        if (pos == 2'd3) begin
          scan_angle = dial_angle;
          scan_pos   = 2'd0;
          blank_zero = 1'b0;
        end else begin
          scan_pos = pos + 2'd1;
        end
        sent = 1'b1;
      end
      OP_HOUR: begin
        hour       = hour + 4'd1;
        chime_done = 1'b0;
        dial_angle = dial_angle + DIAL_STEP;
        if (hour > HOUR_MAX) begin
          frame[0]   = 8'h00;
          frame[1]   = 8'h00;
          frame[2]   = 8'h00;
          hour       = '0;
          dial_angle = '0;
        end
      end
      OP_BEEP: begin
        if (chime_active) begin
          if (beeps_left != '0 && beeps_left <= HOUR_MAX) begin
            if (beep_phase) begin
              tone       = 1'b1;
              beep_phase = 1'b0;
            end else begin
              tone       = 1'b0;
              beep_phase = 1'b1;
              beeps_left = beeps_left - 4'd1;
            end
          end else begin
            chime_active = 1'b0;
            chime_done   = 1'b1;
          end
        end
      end
      OP_MUTE:   muted = !muted;
      OP_LIGHT:  boost = !boost;
      OP_SAMPLE: backlight = 16'(32'(sample) * (boost ? 32'd12 : 32'd4));
      default: begin
      end
    endcase
    status.frame_send      = sent;
    status.frame_byte0     = sent ? frame[0] : 8'h00;
    status.frame_byte1     = sent ? frame[1] : 8'h00;
    status.frame_byte2     = sent ? frame[2] : 8'h00;
    status.tone_on         = tone;
    status.mute_led        = muted;
    status.boost_led       = boost;
    status.backlight_level = backlight;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hour         = '0;
      dial_angle   = '0;
      scan_angle   = '0;
      scan_pos     = 2'd0;
      blank_zero   = 1'b0;
      frame[0]     = 8'h00;
      frame[1]     = 8'h00;
      frame[2]     = 8'h00;
      chime_active = 1'b0;
      chime_done   = 1'b0;
      beeps_left   = '0;
      beep_phase   = 1'b0;
      tone         = 1'b0;
      muted        = 1'b0;
      boost        = 1'b0;
      backlight    = '0;
      fault_count  = 0;
      expected_status_q.delete();
      outstanding_o <= 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_event(cddc_op_e'(s_axis_tuser_i), s_axis_tdata_i[SAMPLE_W-1:0], predicted);
        expected_status_q.push_back(predicted);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        observed = {m_axis_tuser_i, m_axis_tdata_i[7:0], m_axis_tdata_i[15:8],
                    m_axis_tdata_i[23:16], m_axis_tdata_i[24], m_axis_tdata_i[25],
                    m_axis_tdata_i[26], m_axis_tdata_i[42:27]};
        if (expected_status_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fault_count++;
        end else begin
          predicted = expected_status_q.pop_front();
          if (observed.frame_send !== predicted.frame_send) begin
            $error("frame_send: expected %0h, got %0h",
                   predicted.frame_send, observed.frame_send);
            fault_count++;
          end
          if (observed.frame_byte0 !== predicted.frame_byte0) begin
            $error("frame_byte0: expected %02h, got %02h",
                   predicted.frame_byte0, observed.frame_byte0);
            fault_count++;
          end
          if (observed.frame_byte1 !== predicted.frame_byte1) begin
            $error("frame_byte1: expected %02h, got %02h",
                   predicted.frame_byte1, observed.frame_byte1);
            fault_count++;
          end
          if (observed.frame_byte2 !== predicted.frame_byte2) begin
            $error("frame_byte2: expected %02h, got %02h",
                   predicted.frame_byte2, observed.frame_byte2);
            fault_count++;
          end
          if (observed.tone_on !== predicted.tone_on) begin
            $error("tone_on: expected %0h, got %0h", predicted.tone_on, observed.tone_on);
            fault_count++;
          end
          if (observed.mute_led !== predicted.mute_led) begin
            $error("mute_led: expected %0h, got %0h", predicted.mute_led, observed.mute_led);
            fault_count++;
          end
          if (observed.boost_led !== predicted.boost_led) begin
            $error("boost_led: expected %0h, got %0h",
                   predicted.boost_led, observed.boost_led);
            fault_count++;
          end
          if (observed.backlight_level !== predicted.backlight_level) begin
            $error("backlight_level: expected %0d, got %0d",
                   predicted.backlight_level, observed.backlight_level);
            fault_count++;
          end
        end
      end
      outstanding_o <= expected_status_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
// Top of the clock_dial_display_chime testbench: clock, reset, event stimulus and the
// verdict. Depends on cddc_pkg, the block's RTL and chime_display_checker.
`timescale 1ns / 1ps

module testbench;
  import cddc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 550;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [15:0]     s_axis_tdata;
  logic [OP_W-1:0] s_axis_tuser;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [47:0]     m_axis_tdata;
  logic            m_axis_tuser;
  int unsigned     mismatches;
  int unsigned     outstanding;
  int unsigned     cycles = 0;
  int unsigned     issued;
  logic            sender_steady;
  logic            receiver_steady;

  clock_dial_display_chime DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  chime_display_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .m_axis_tuser_i  (m_axis_tuser),
    .mismatches_o    (mismatches),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL clock_dial_display_chime");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: stall at random, with stretches of steady acceptance.
  initial begin
    int unsigned stall;
    stall = 0;
    receiver_steady = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) receiver_steady = !receiver_steady;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!receiver_steady && $urandom_range(0, 99) < 25) stall = idle_length();
      end
    end
  end

  // Offer one event; valid stays high into the next transaction when no gap is drawn.
  task automatic send_event(input cddc_op_e op, input logic [SAMPLE_W-1:0] sample);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 49) == 0) sender_steady = !sender_steady;
    if (!sender_steady && $urandom_range(0, 99) < 30) gap = idle_length();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0000, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    issued++;
  endtask

  // Hold off until every predicted result has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] any_sample();
    return SAMPLE_W'($urandom_range(0, 4095));
  endfunction

  // One hour: tick, a full scan of the four positions, then mostly beeps.
  task automatic play_hour();
    int unsigned beeps;
    send_event(OP_HOUR, any_sample());
    repeat (4) send_event(OP_SCAN, any_sample());
    beeps = $urandom_range(0, 26);
    repeat (beeps) begin
      if ($urandom_range(0, 9) == 0) send_event(OP_SCAN, any_sample());
      else                           send_event(OP_BEEP, any_sample());
    end
  endtask

  initial begin
    issued        = 0;
    sender_steady = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = OP_SCAN;
    s_axis_tdata  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // backlight extremes at normal sensitivity, full scale when boosted
    send_event(OP_SAMPLE, 12'hFFF);
    send_event(OP_SAMPLE, 12'h000);
    send_event(OP_LIGHT, 12'h000);
    send_event(OP_SAMPLE, 12'hFFF);
    send_event(OP_LIGHT, 12'hFFF);
    // beep with no chime armed
    send_event(OP_BEEP, 12'h000);
    // muted scans at hour zero: no hour LED, no degree sign, no chime
    send_event(OP_MUTE, 12'h000);
    repeat (4) send_event(OP_SCAN, 12'h000);
    send_event(OP_MUTE, 12'h000);
    // chime armed at hour zero ends on the next beep
    send_event(OP_SCAN, 12'h000);
    send_event(OP_BEEP, 12'h000);
    send_event(OP_HOUR, 12'h000);
    repeat (4) send_event(OP_SCAN, 12'hFFF);
    repeat (3) send_event(OP_BEEP, 12'hFFF);
    wait_drained();

    while (issued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 60) play_hour();
      else send_event(cddc_op_e'($urandom_range(0, 5)), any_sample());
      if (issued > 300 && issued < 330 && $urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS clock_dial_display_chime");
    end else begin
      $display("FAIL clock_dial_display_chime");
    end
    $finish;
  end

endmodule
